// ===== src/glmd_pkg.sv =====
// Shared types and constants for the grid local maximum detector.
package glmd_pkg;

   // Widths of the item fields and configuration registers.
   localparam int VALUE_BITS = 32;
   localparam int ROW_BITS = 7;
   localparam int CFG_BITS = 8;
   localparam int ROW_LIMIT = 128;

   // An item can cause at most three results.
   localparam int RUN_MAX = 3;
   localparam int RUN_CNT_BITS = $clog2(RUN_MAX + 1);

   // Result queue sizing.
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   // Register port sizing.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes.
   typedef enum logic {
      REG_GRID_ROWS = 1'b0,
      REG_GRID_COLS = 1'b1
   } reg_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [CFG_BITS-1:0] grid_rows;
      logic [CFG_BITS-1:0] grid_cols;
      logic                restart;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [VALUE_BITS-1:0] peak_value;
      logic [ROW_BITS-1:0]   peak_row;
      logic [ROW_BITS-1:0]   peak_col;
      logic                  last_of_run;
   } result_type;

   // The results one item causes, packed from entry 0 upward.
   typedef struct packed {
      logic [RUN_CNT_BITS-1:0]      count;
      result_type [RUN_MAX-1:0]     entry;
   } push_type;

endpackage

// ===== src/glmd_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module glmd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports return the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== src/glmd_csr.sv =====
// Register file for the grid size, with the grid restart on every write.
module glmd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [glmd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [glmd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [glmd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output glmd_pkg::cfg_type                    cfg
);

   localparam int CFG_BITS = glmd_pkg::CFG_BITS;
   localparam int DATA_BITS = glmd_pkg::CSR_DATA_BITS;

   logic [CFG_BITS-1:0]     grid_rows_ff;
   logic [CFG_BITS-1:0]     grid_rows_in;
   logic [CFG_BITS-1:0]     grid_cols_ff;
   logic [CFG_BITS-1:0]     grid_cols_in;
   logic                    write_en;
   glmd_pkg::reg_index_type index;

   // The word address picks the register.
   assign index = glmd_pkg::reg_index_type'(csr_paddr[2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Next register values.
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (write_en) begin
         case (index)
            glmd_pkg::REG_GRID_ROWS: grid_rows_in = csr_pwdata[CFG_BITS-1:0];
            glmd_pkg::REG_GRID_COLS: grid_cols_in = csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CFG_BITS'(2);
         grid_cols_ff <= CFG_BITS'(2);
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   // Read data.
   always_comb begin
      case (index)
         glmd_pkg::REG_GRID_ROWS: csr_prdata = DATA_BITS'(grid_rows_ff);
         glmd_pkg::REG_GRID_COLS: csr_prdata = DATA_BITS'(grid_cols_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Any write restarts the grid at its first pixel.
   assign cfg.grid_rows = grid_rows_ff;
   assign cfg.grid_cols = grid_cols_ff;
   assign cfg.restart   = write_en;

endmodule

// ===== src/glmd_peak_fifo.sv =====
// Result queue that takes up to three results a cycle and hands out one.
module glmd_peak_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  glmd_pkg::push_type                   push,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output glmd_pkg::result_type                 out_item,
   output logic [glmd_pkg::FIFO_CNT_BITS-1:0]   level
);

   localparam int DEPTH = glmd_pkg::FIFO_DEPTH;
   localparam int PTR_BITS = glmd_pkg::FIFO_PTR_BITS;
   localparam int CNT_BITS = glmd_pkg::FIFO_CNT_BITS;
   localparam int RUN_MAX = glmd_pkg::RUN_MAX;

   glmd_pkg::result_type fifo_ff [DEPTH];
   logic [PTR_BITS-1:0]  head_ff;
   logic [PTR_BITS-1:0]  head_in;
   logic [PTR_BITS-1:0]  tail_ff;
   logic [PTR_BITS-1:0]  tail_in;
   logic [CNT_BITS-1:0]  level_ff;
   logic [CNT_BITS-1:0]  level_in;
   logic                 pop;

   assign out_valid = level_ff != '0;
   assign pop = out_valid && out_ready;
   assign out_item = fifo_ff[head_ff];
   assign level = level_ff;

   // Store the results of one item in order at the tail.
   always_ff @(posedge clock) begin
      for (int k = 0; k < RUN_MAX; k++) begin
         if (k < push.count) begin
            fifo_ff[tail_ff + PTR_BITS'(k)] <= push.entry[k];
         end
      end
   end

   // Pointer and fill level update.
   always_comb begin
      tail_in  = tail_ff + PTR_BITS'(push.count);
      head_in  = head_ff + PTR_BITS'(pop);
      level_in = level_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

endmodule

// ===== src/glmd_detect.sv =====
// Raster position, line store and the neighbour compares for one pixel a cycle.
module glmd_detect #(
   parameter int MAX_COLS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  glmd_pkg::cfg_type                    cfg,
   input  logic                                 in_accept,
   input  logic [glmd_pkg::VALUE_BITS-1:0]      in_value,
   output logic                                 busy,
   output glmd_pkg::push_type                   push
);

   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int VB = glmd_pkg::VALUE_BITS;
   localparam int ROW_BITS = glmd_pkg::ROW_BITS;
   localparam int CFG_BITS = glmd_pkg::CFG_BITS;
   localparam int RUN_MAX = glmd_pkg::RUN_MAX;
   localparam int RUN_CNT_BITS = glmd_pkg::RUN_CNT_BITS;
   localparam int WORD_BITS = 2 * VB;

   // Signed greater-than on stored values.
   function automatic logic above(input logic [VB-1:0] a, input logic [VB-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

   logic [COL_BITS-1:0]  last_col;
   logic [ROW_BITS-1:0]  last_row;

   logic [ROW_BITS-1:0]  row_ff;
   logic [ROW_BITS-1:0]  row_in;
   logic [COL_BITS-1:0]  col_ff;
   logic [COL_BITS-1:0]  col_in;

   logic                 s1_valid_ff;
   logic [VB-1:0]        s1_value_ff;
   logic [ROW_BITS-1:0]  s1_row_ff;
   logic [COL_BITS-1:0]  s1_col_ff;

   logic [VB-1:0]        left_cur_ff;
   logic [VB-1:0]        left2_cur_ff;
   logic [VB-1:0]        left_up_ff;

   logic                 byp_a_ff;
   logic                 byp_b_ff;
   logic [WORD_BITS-1:0] byp_data_ff;

   logic [COL_BITS-1:0]  rd_addr_b;
   logic [WORD_BITS-1:0] rd_data_a;
   logic [WORD_BITS-1:0] rd_data_b;
   logic [WORD_BITS-1:0] word_a;
   logic [WORD_BITS-1:0] word_b;
   logic [WORD_BITS-1:0] wr_data;
   logic [VB-1:0]        up_val;
   logic [VB-1:0]        up2_val;
   logic [VB-1:0]        up_right_val;

   logic                 has_up;
   logic                 has_up2;
   logic                 has_left;
   logic                 has_left2;
   logic                 at_last_row;
   logic                 at_last_col;
   logic [RUN_MAX-1:0]   hit;
   glmd_pkg::result_type cand [RUN_MAX];

   // Clamp the configured grid size to what the block supports.
   always_comb begin
      if (cfg.grid_cols < CFG_BITS'(2)) begin
         last_col = COL_BITS'(1);
      end else if (32'(cfg.grid_cols) > MAX_COLS) begin
         last_col = COL_BITS'(MAX_COLS - 1);
      end else begin
         last_col = COL_BITS'(cfg.grid_cols - CFG_BITS'(1));
      end
      if (cfg.grid_rows < CFG_BITS'(2)) begin
         last_row = ROW_BITS'(1);
      end else if (32'(cfg.grid_rows) > glmd_pkg::ROW_LIMIT) begin
         last_row = ROW_BITS'(glmd_pkg::ROW_LIMIT - 1);
      end else begin
         last_row = ROW_BITS'(cfg.grid_rows - CFG_BITS'(1));
      end
   end

   // Raster position of the next item, wrapping at the end of the grid.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cfg.restart) begin
         row_in = '0;
         col_in = '0;
      end else if (in_accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line store: each word holds the two previous rows at one column as
   // {older row, prior row}. The item's own column and the one to its right
   // are read as it is accepted; the pixel in the compare stage writes back.
   assign rd_addr_b = col_ff + COL_BITS'(1);

   glmd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_data   (wr_data),
      .rd_en     (in_accept),
      .rd_addr_a (col_ff),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // A read that meets the write of the pixel ahead takes the written word.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
      end else if (in_accept) begin
         byp_a_ff <= s1_valid_ff && (s1_col_ff == col_ff);
         byp_b_ff <= s1_valid_ff && (s1_col_ff == rd_addr_b);
      end
   end

   assign word_a = byp_a_ff ? byp_data_ff : rd_data_a;
   assign word_b = byp_b_ff ? byp_data_ff : rd_data_b;
   assign up_val = word_a[VB-1:0];
   assign up2_val = word_a[WORD_BITS-1:VB];
   assign up_right_val = word_b[VB-1:0];
   assign wr_data = {up_val, s1_value_ff};

   // Compare stage register.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_value_ff <= in_value;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
      end
   end

   assign busy = s1_valid_ff;

   // Recent pixels of the current and previous row, to the left.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         left_cur_ff  <= s1_value_ff;
         left2_cur_ff <= left_cur_ff;
         left_up_ff   <= up_val;
      end
   end

   // Decide the pixel above, the pixel to the left in the last row, and the
   // last pixel of the grid.
   always_comb begin
      has_up      = s1_row_ff != '0;
      has_up2     = s1_row_ff > ROW_BITS'(1);
      has_left    = s1_col_ff != '0;
      has_left2   = s1_col_ff > COL_BITS'(1);
      at_last_row = s1_row_ff == last_row;
      at_last_col = s1_col_ff == last_col;

      hit[0] = s1_valid_ff && has_up && above(up_val, s1_value_ff)
               && (!has_up2 || above(up_val, up2_val))
               && (!has_left || above(up_val, left_up_ff))
               && (at_last_col || above(up_val, up_right_val));
      hit[1] = s1_valid_ff && at_last_row && has_left && above(left_cur_ff, s1_value_ff)
               && (!has_left2 || above(left_cur_ff, left2_cur_ff))
               && above(left_cur_ff, left_up_ff);
      hit[2] = s1_valid_ff && at_last_row && at_last_col
               && above(s1_value_ff, left_cur_ff) && above(s1_value_ff, up_val);

      cand[0].peak_value  = up_val;
      cand[0].peak_row    = s1_row_ff - ROW_BITS'(1);
      cand[0].peak_col    = ROW_BITS'(s1_col_ff);
      cand[0].last_of_run = 1'b0;
      cand[1].peak_value  = left_cur_ff;
      cand[1].peak_row    = s1_row_ff;
      cand[1].peak_col    = ROW_BITS'(s1_col_ff - COL_BITS'(1));
      cand[1].last_of_run = 1'b0;
      cand[2].peak_value  = s1_value_ff;
      cand[2].peak_row    = s1_row_ff;
      cand[2].peak_col    = ROW_BITS'(s1_col_ff);
      cand[2].last_of_run = 1'b0;
   end

   // Pack the hits in raster order and flag the last one.
   always_comb begin
      logic [RUN_CNT_BITS-1:0] n;
      n = '0;
      push = '0;
      for (int k = 0; k < RUN_MAX; k++) begin
         if (hit[k]) begin
            push.entry[n] = cand[k];
            n = n + RUN_CNT_BITS'(1);
         end
      end
      push.count = n;
      if (n != '0) begin
         push.entry[n - RUN_CNT_BITS'(1)].last_of_run = 1'b1;
      end
   end

endmodule

// ===== src/grid_local_maximum_detect_core.sv =====
// Top level of the four-neighbour grid local maximum detector.
//
// Pixels enter in raster order on the req_ channel, one item per valid/ready
// handshake, and the grid size comes from the grid_rows and grid_cols
// registers on the csr_ port. Each value strictly greater than all the up,
// down, left and right neighbours it has leaves on the rsp_ channel with its
// row and column. A pixel is decided when its lower neighbour arrives, or
// in the last row when its right neighbour arrives, so one item causes zero
// to three results; last_of_run marks the last result of an item.
// Throughput is one item per cycle while req_ready stays high: a line store with
// two read ports and a compare stage supply all neighbours. The results of an
// item pass through the compare stage register and then the result queue.
// Results wait in a 16-entry queue; req_ready drops while that queue could
// not take the results of the item in the compare stage and of one more item,
// so a stalled receiver holds back the input after a few items.
// Reset empties the queue and the compare stage, sets both registers to 2 and
// starts at row 0, column 0. A register write also restarts the grid there.
module grid_local_maximum_detect_core #(
   parameter int MAX_COLS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [31:0]                   req_pixel_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_peak_value,
   output logic [6:0]                           rsp_peak_row,
   output logic [6:0]                           rsp_peak_col,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [glmd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [glmd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [glmd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int CNT_BITS = glmd_pkg::FIFO_CNT_BITS;
   localparam int DEMAND_BITS = CNT_BITS + 1;

   glmd_pkg::cfg_type    cfg;
   glmd_pkg::push_type   push;
   glmd_pkg::result_type out_item;
   logic                 in_accept;
   logic                 busy;
   logic [CNT_BITS-1:0]  level;
   logic [DEMAND_BITS-1:0] demand;

   // Configuration registers.
   glmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accept only while the queue has room for two items' worth of results.
   assign demand = DEMAND_BITS'(level)
                   + (busy ? DEMAND_BITS'(glmd_pkg::RUN_MAX) : DEMAND_BITS'(0));
   assign req_ready = demand <= DEMAND_BITS'(glmd_pkg::FIFO_DEPTH - glmd_pkg::RUN_MAX);
   assign in_accept = req_valid && req_ready;

   // Neighbour compares.
   glmd_detect #(
      .MAX_COLS (MAX_COLS)
   ) u_detect (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (in_accept),
      .in_value  (req_pixel_value),
      .busy      (busy),
      .push      (push)
   );

   // Result queue.
   glmd_peak_fifo u_peak_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item),
      .level     (level)
   );

   assign rsp_peak_value  = out_item.peak_value;
   assign rsp_peak_row    = out_item.peak_row;
   assign rsp_peak_col    = out_item.peak_col;
   assign rsp_last_of_run = out_item.last_of_run;

endmodule

// ===== src/glmd_checker.sv =====
// Port-level checks for the grid local maximum detector, bound to the top level.
module glmd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_peak_value,
   input logic [6:0]         rsp_peak_row,
   input logic [6:0]         rsp_peak_col,
   input logic               rsp_last_of_run
);

   // A stalled result holds still.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_value)
            && $stable(rsp_peak_row) && $stable(rsp_peak_col)
            && $stable(rsp_last_of_run);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp item changed while stalled");

   // All results of one item are queued together, so a run never has a gap.
   property p_run_unbroken;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid;
   endproperty
   a_run_unbroken: assert property (p_run_unbroken) else $error("run of results broken");

   // After reset nothing is pending and the block takes input.
   property p_reset_idle;
      @(posedge clock) reset |=> !rsp_valid && req_ready;
   endproperty
   a_reset_idle: assert property (p_reset_idle) else $error("block not idle after reset");

endmodule

bind grid_local_maximum_detect_core glmd_checker u_glmd_checker (.*);

// ===== bench/grid_local_maximum_detect_core_tb.sv =====
// Self-checking testbench for the four-neighbour grid local maximum detector.
module grid_local_maximum_detect_core_tb;

   localparam int MAX_COLS = 128;
   localparam int VALUE_BITS = glmd_pkg::VALUE_BITS;
   localparam int ROW_BITS = glmd_pkg::ROW_BITS;
   localparam int CFG_BITS = glmd_pkg::CFG_BITS;
   localparam int ROW_LIMIT = glmd_pkg::ROW_LIMIT;
   localparam int CSR_ADDR_BITS = glmd_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = glmd_pkg::CSR_DATA_BITS;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 95;
   localparam int QUIET_ITEMS = 30;
   localparam int PRESSURE_ITEMS = 40;
   localparam int CLAMP_ITEMS = 12;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // Tracks the grid position and line stores and keeps the peaks still owed.
   class peak_scoreboard;
      logic [CFG_BITS-1:0] rows_reg = 8'd2;
      logic [CFG_BITS-1:0] cols_reg = 8'd2;
      logic signed [VALUE_BITS-1:0] prior_line [MAX_COLS];
      logic signed [VALUE_BITS-1:0] older_line [MAX_COLS];
      int unsigned row_pos = 0;
      int unsigned col_pos = 0;
      glmd_pkg::result_type pending_peaks [$];
      int unsigned error_count = 0;

      // Sizes outside the legal range act as the nearest limit.
      function int unsigned clamp_size(logic [CFG_BITS-1:0] size, int unsigned limit);
         if (size < 2) return 2;
         if (size > limit) return limit;
         return size;
      endfunction

      // Any register write restarts the grid.
      function void apply_register(glmd_pkg::reg_index_type index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == glmd_pkg::REG_GRID_ROWS) rows_reg = data[CFG_BITS-1:0];
         else cols_reg = data[CFG_BITS-1:0];
         row_pos = 0;
         col_pos = 0;
      endfunction

      function void add_peak(logic signed [VALUE_BITS-1:0] value, int unsigned row,
                             int unsigned col);
         pending_peaks.push_back(glmd_pkg::result_type'{peak_value: value,
                                                        peak_row: ROW_BITS'(row),
                                                        peak_col: ROW_BITS'(col),
                                                        last_of_run: 1'b0});
      endfunction

      // Decide every pixel whose last missing neighbour is this item.
      function void note_pixel(logic signed [VALUE_BITS-1:0] value);
         int unsigned rows;
         int unsigned cols;
         int unsigned i;
         int unsigned j;
         int first;
         logic signed [VALUE_BITS-1:0] c;
         bit ok;
         rows = clamp_size(rows_reg, ROW_LIMIT);
         cols = clamp_size(cols_reg, MAX_COLS);
         i = row_pos;
         j = col_pos;
         first = pending_peaks.size();

         // The pixel above now has its lower neighbour.
         if (i >= 1) begin
            c = prior_line[j];
            ok = c > value;
            if (i >= 2) ok = ok && (c > older_line[j]);
            if (j >= 1) ok = ok && (c > older_line[j - 1]);
            if (j + 1 < cols) ok = ok && (c > prior_line[j + 1]);
            if (ok) add_peak(c, i - 1, j);
         end

         older_line[j] = prior_line[j];
         prior_line[j] = value;

         // In the last row the left pixel is decided by its right neighbour.
         if (i == rows - 1) begin
            if (j >= 1) begin
               c = prior_line[j - 1];
               ok = (c > value) && (c > older_line[j - 1]);
               if (j >= 2) ok = ok && (c > prior_line[j - 2]);
               if (ok) add_peak(c, i, j - 1);
            end
            // The final pixel of the grid is decided on its own arrival.
            if (j == cols - 1) begin
               ok = (value > prior_line[j - 1]) && (value > older_line[j]);
               if (ok) add_peak(value, i, j);
            end
         end

         if (pending_peaks.size() > first)
            pending_peaks[pending_peaks.size() - 1].last_of_run = 1'b1;

         j++;
         if (j >= cols) begin
            j = 0;
            i++;
            if (i >= rows) i = 0;
         end
         row_pos = i;
         col_pos = j;
      endfunction

      // Compare one delivered peak with the oldest one owed.
      function void check_peak(glmd_pkg::result_type actual);
         glmd_pkg::result_type wanted;
         if (pending_peaks.size() == 0) begin
            $error("unexpected peak: value %0d row %0d col %0d",
                   $signed(actual.peak_value), actual.peak_row, actual.peak_col);
            error_count++;
            return;
         end
         wanted = pending_peaks.pop_front();
         if (actual.peak_value !== wanted.peak_value) begin
            $error("peak_value: expected %0d, actual %0d",
                   $signed(wanted.peak_value), $signed(actual.peak_value));
            error_count++;
         end
         if (actual.peak_row !== wanted.peak_row) begin
            $error("peak_row: expected %0d, actual %0d", wanted.peak_row, actual.peak_row);
            error_count++;
         end
         if (actual.peak_col !== wanted.peak_col) begin
            $error("peak_col: expected %0d, actual %0d", wanted.peak_col, actual.peak_col);
            error_count++;
         end
         if (actual.last_of_run !== wanted.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   wanted.last_of_run, actual.last_of_run);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pixel_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_peak_value;
   logic [6:0] rsp_peak_row;
   logic [6:0] rsp_peak_col;
   logic rsp_last_of_run;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   bit idle_off = 1'b0;
   bit hold_results = 1'b0;
   peak_scoreboard peaks = new();

   grid_local_maximum_detect_core #(.MAX_COLS(MAX_COLS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_peak_value(rsp_peak_value),
      .rsp_peak_row(rsp_peak_row),
      .rsp_peak_col(rsp_peak_col),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Offer one pixel, sometimes after a short gap, and hold it until taken.
   task automatic send_pixel(input logic signed [31:0] value);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      peaks.note_pixel(value);
   endtask

   // Stop offering pixels until every owed peak has been delivered.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (peaks.pending_peaks.size() != 0) @(posedge clock);
   endtask

   // Setup and access cycle; the upper data bits are noise.
   task automatic write_register(input glmd_pkg::reg_index_type index,
                                 input logic [7:0] value);
      logic [CSR_DATA_BITS-1:0] data;
      data = $urandom;
      data[7:0] = value;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      peaks.apply_register(index, data);
   endtask

   // Mix of full-range values, small values that tie often, and extremes.
   function automatic logic signed [31:0] pick_pixel();
      case ($urandom_range(0, 9))
         0, 1, 2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h7FFF_FFFE;
               default: return 32'h8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_grid(input logic [7:0] rows, input logic [7:0] cols,
                                   input int unsigned count);
      write_register(glmd_pkg::REG_GRID_ROWS, rows);
      write_register(glmd_pkg::REG_GRID_COLS, cols);
      for (int unsigned n = 0; n < count; n++) send_pixel(pick_pixel());
   endtask

   // Checkerboard of high and low values, so that about half the pixels are peaks.
   task automatic send_checker_grid(input logic [7:0] rows, input logic [7:0] cols,
                                    input int unsigned count);
      logic signed [31:0] value;
      write_register(glmd_pkg::REG_GRID_ROWS, rows);
      write_register(glmd_pkg::REG_GRID_COLS, cols);
      for (int unsigned n = 0; n < count; n++) begin
         if (((peaks.row_pos + peaks.col_pos) & 1) == 0)
            value = $urandom_range(100, 1000);
         else
            value = 32'sd0 - 32'($urandom_range(1, 50));
         send_pixel(value);
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int unsigned gap;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!idle_off && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Check every delivered peak.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         peaks.check_peak(glmd_pkg::result_type'{peak_value: rsp_peak_value,
                                                 peak_row: rsp_peak_row,
                                                 peak_col: rsp_peak_col,
                                                 last_of_run: rsp_last_of_run});
   end

   // Watchdog: end the run if no item moves on either channel for too long.
   initial begin
      int unsigned still_cycles;
      still_cycles = 0;
      while (still_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) still_cycles = 0;
         else still_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // Main sequence: directed grids, a grid under pressure, random grids.
   initial begin
      int unsigned random_count;
      int unsigned phase_len;
      int unsigned drain_at;
      int unsigned set_rows;
      int unsigned set_cols;
      int unsigned grid_size;
      random_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size 2x2: extreme values give one peak at each corner pair.
      send_pixel(32'h7FFF_FFFF);
      send_pixel(32'h8000_0000);
      send_pixel(32'h8000_0000);
      send_pixel(32'h7FFF_FFFE);
      // Equal values are never peaks.
      send_pixel(32'sd5);
      send_pixel(32'sd5);
      send_pixel(32'sd5);
      send_pixel(32'sd5);

      // Two rows of three: the final item yields two peaks.
      write_register(glmd_pkg::REG_GRID_COLS, 8'd3);
      send_pixel(32'sd0);
      send_pixel(32'sd0);
      send_pixel(32'sd9);
      send_pixel(32'sd0);
      send_pixel(32'sd7);
      send_pixel(32'sd1);

      // Three by three with a center peak and alternating bit patterns.
      write_register(glmd_pkg::REG_GRID_ROWS, 8'd3);
      send_pixel(32'hAAAA_AAAA);
      send_pixel(32'h8000_0001);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      send_pixel(32'h5555_5555);
      send_pixel(32'h0000_0001);
      send_pixel(32'h8000_0000);
      send_pixel(32'h5555_5554);
      send_pixel(32'h7FFF_FFFF);

      // Tall clamped grid full of peaks, receiver held off while pixels flow.
      wait_for_results();
      hold_results = 1'b1;
      send_checker_grid(8'd255, 8'd1, PRESSURE_ITEMS);
      // Row count clamped up and column count above the limit.
      send_random_grid(8'd1, 8'd200, CLAMP_ITEMS);

      // Small random grids, often cut short by the next register write.
      while (random_count < RANDOM_ITEMS) begin
         set_rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         set_cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
         grid_size = (set_rows < 2 ? 2 : set_rows) * (set_cols < 2 ? 2 : set_cols);
         phase_len = $urandom_range(1, 3 * grid_size);
         drain_at = $urandom_range(0, phase_len - 1);
         write_register(glmd_pkg::REG_GRID_ROWS, 8'(set_rows));
         write_register(glmd_pkg::REG_GRID_COLS, 8'(set_cols));
         for (int unsigned n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
            if (random_count + QUIET_ITEMS >= RANDOM_ITEMS) idle_off = 1'b1;
            if (n == drain_at && $urandom_range(0, 2) == 0) wait_for_results();
            send_pixel(pick_pixel());
            random_count++;
         end
      end

      idle_off = 1'b1;
      wait_for_results();
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (peaks.error_count == 0 && peaks.pending_peaks.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/glmd_pkg.sv
src/glmd_ram.sv
src/glmd_csr.sv
src/glmd_peak_fifo.sv
src/glmd_detect.sv
src/grid_local_maximum_detect_core.sv
src/glmd_checker.sv
bench/grid_local_maximum_detect_core_tb.sv
